// ===== hdl/mmsv_pkg.sv =====
// types and constants for the motor matrix scan and vend controller
// depends on nothing; used by motor_matrix_scan_vend_controller
package mmsv_pkg;

	localparam int unsigned THR_W  = 10;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned POS_W  = 3;
	localparam int unsigned LINES  = 8;
	localparam int unsigned MAP_W  = LINES * LINES;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 2;

	// input opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_VEND  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_SETTLE    = 2'd1;
	localparam logic [IDX_W-1:0] REG_START     = 2'd2;
	localparam logic [IDX_W-1:0] REG_RUN       = 2'd3;

	// register reset values
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 10'd100;
	localparam logic [TICK_W-1:0] SETTLE_RST    = 16'd20;
	localparam logic [TICK_W-1:0] START_RST     = 16'd400;
	localparam logic [TICK_W-1:0] RUN_RST       = 16'd3000;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
	localparam logic [POS_W-1:0]  POS_LAST = 3'd7;

	typedef enum logic [2:0] {
		MODE_UNKNOWN  = 3'b001,
		MODE_SCANNING = 3'b010,
		MODE_IDLE     = 3'b100
	} mode_t;

	typedef enum logic [3:0] {
		PH_NONE  = 4'b0001,
		PH_SCAN  = 4'b0010,
		PH_START = 4'b0100,
		PH_WAIT  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [THR_W-1:0] sample;
	} item_t;

endpackage

// ===== hdl/motor_matrix_scan_vend_controller.sv =====
// motor matrix scan and vend controller: input register, state update, result register
// depends on mmsv_pkg
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------------
//  in      | in_valid / in_stall     | op, row, col, sense_sample
//  out     | out_valid / out_stall   | row_drive, col_drive, motor_enable, present,
//          |                         | vend_accepted, scanning, vending
//  cfg     | cfg_we (no wait)        | cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low; an item passes the input register,
// then the result register, before its result shows on the out port
// the single state update between the two registers sets the rate of one item a cycle
// reset clears mode, phase, tick counter, selection and presence map at once; registers
// return to their default values
// out_stall holds the result register and then the input register; in_stall rises only
// when the input register is full and cannot move on
module motor_matrix_scan_vend_controller (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [2:0]  row,
	input  logic [2:0]  col,
	input  logic [9:0]  sense_sample,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  row_drive,
	output logic [7:0]  col_drive,
	output logic        motor_enable,
	output logic        present,
	output logic        vend_accepted,
	output logic        scanning,
	output logic        vending,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [mmsv_pkg::THR_W-1:0]  threshold_q;
	logic [mmsv_pkg::TICK_W-1:0] settle_q;
	logic [mmsv_pkg::TICK_W-1:0] start_q;
	logic [mmsv_pkg::TICK_W-1:0] run_q;

	// controller state
	mmsv_pkg::mode_t             mode_q, mode_d;
	mmsv_pkg::phase_t            phase_q, phase_d;
	logic [mmsv_pkg::TICK_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [mmsv_pkg::POS_W-1:0]  cur_row_q, cur_row_d;
	logic [mmsv_pkg::POS_W-1:0]  cur_col_q, cur_col_d;
	logic [mmsv_pkg::MAP_W-1:0]  presence_q, presence_d;

	// input register
	mmsv_pkg::item_t item_s1;
	logic            valid_s1;

	// result register
	logic       out_valid_q;
	logic [7:0] row_drive_q, col_drive_q;
	logic       enable_q, present_q, accepted_q, scanning_q;

	// per-item results
	logic       present_d, accepted_d, enable_d;
	logic [7:0] row_drive_d, col_drive_d;

	logic out_free, advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= mmsv_pkg::THRESHOLD_RST;
			settle_q    <= mmsv_pkg::SETTLE_RST;
			start_q     <= mmsv_pkg::START_RST;
			run_q       <= mmsv_pkg::RUN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mmsv_pkg::REG_THRESHOLD: threshold_q <= cfg_data[mmsv_pkg::THR_W-1:0];
				mmsv_pkg::REG_SETTLE:    settle_q    <= cfg_data;
				mmsv_pkg::REG_START:     start_q     <= cfg_data;
				mmsv_pkg::REG_RUN:       run_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: loads whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{op: op, row: row, col: col, sample: sense_sample};
		end
	end

	// tick counter saturates at full scale
	assign elapsed_inc = (elapsed_q == mmsv_pkg::TICK_MAX) ? elapsed_q
		: elapsed_q + mmsv_pkg::TICK_W'(1);

	// state update for the item in the input register
	always_comb begin
		mode_d     = mode_q;
		phase_d    = phase_q;
		elapsed_d  = elapsed_q;
		cur_row_d  = cur_row_q;
		cur_col_d  = cur_col_q;
		presence_d = presence_q;
		present_d  = 1'b0;
		accepted_d = 1'b0;

		case (item_s1.op)
			mmsv_pkg::OP_TICK: begin
				elapsed_d = elapsed_inc;
				if (mode_q != mmsv_pkg::MODE_IDLE) begin
					// first tick after reset starts the scan
					mode_d = mmsv_pkg::MODE_SCANNING;
					if (phase_q != mmsv_pkg::PH_SCAN) begin
						phase_d   = mmsv_pkg::PH_SCAN;
						elapsed_d = '0;
					end else if (elapsed_inc >= settle_q) begin
						// settled: sample, release and step to the next position
						if (item_s1.sample < threshold_q) begin
							presence_d[{cur_row_q, cur_col_q}] = 1'b1;
						end
						phase_d = mmsv_pkg::PH_NONE;
						if (cur_col_q == mmsv_pkg::POS_LAST) begin
							cur_col_d = '0;
							if (cur_row_q == mmsv_pkg::POS_LAST) begin
								cur_row_d = '0;
								mode_d    = mmsv_pkg::MODE_IDLE;
							end else begin
								cur_row_d = cur_row_q + mmsv_pkg::POS_W'(1);
							end
						end else begin
							cur_col_d = cur_col_q + mmsv_pkg::POS_W'(1);
						end
					end
				end else if (phase_q == mmsv_pkg::PH_START) begin
					if (elapsed_inc >= start_q) begin
						phase_d   = mmsv_pkg::PH_WAIT;
						elapsed_d = '0;
					end
				end else if (phase_q == mmsv_pkg::PH_WAIT) begin
					if (elapsed_inc >= run_q) begin
						phase_d   = mmsv_pkg::PH_NONE;
						cur_row_d = '0;
						cur_col_d = '0;
						elapsed_d = '0;
					end
				end
			end
			mmsv_pkg::OP_VEND: begin
				// only from idle with no motor selected
				if (mode_q == mmsv_pkg::MODE_IDLE &&
				    (phase_q == mmsv_pkg::PH_NONE || phase_q == mmsv_pkg::PH_SCAN)) begin
					cur_row_d  = item_s1.row;
					cur_col_d  = item_s1.col;
					phase_d    = mmsv_pkg::PH_START;
					elapsed_d  = '0;
					accepted_d = 1'b1;
				end
			end
			mmsv_pkg::OP_QUERY: begin
				present_d = presence_q[{item_s1.row, item_s1.col}];
			end
			default: ;
		endcase

		// drive levels follow the new phase
		row_drive_d = (phase_d != mmsv_pkg::PH_NONE) ? (8'd1 << cur_row_d) : 8'd0;
		col_drive_d = (phase_d == mmsv_pkg::PH_SCAN || phase_d == mmsv_pkg::PH_START)
			? (8'd1 << cur_col_d) : 8'd0;
		enable_d    = (phase_d == mmsv_pkg::PH_START || phase_d == mmsv_pkg::PH_WAIT);
	end

	// state commits when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= mmsv_pkg::MODE_UNKNOWN;
			phase_q    <= mmsv_pkg::PH_NONE;
			elapsed_q  <= '0;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			presence_q <= '0;
		end else if (advance) begin
			mode_q     <= mode_d;
			phase_q    <= phase_d;
			elapsed_q  <= elapsed_d;
			cur_row_q  <= cur_row_d;
			cur_col_q  <= cur_col_d;
			presence_q <= presence_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			row_drive_q <= row_drive_d;
			col_drive_q <= col_drive_d;
			enable_q    <= enable_d;
			present_q   <= present_d;
			accepted_q  <= accepted_d;
			scanning_q  <= (mode_d != mmsv_pkg::MODE_IDLE);
		end
	end

	assign out_valid     = out_valid_q;
	assign row_drive     = row_drive_q;
	assign col_drive     = col_drive_q;
	assign motor_enable  = enable_q;
	assign present       = present_q;
	assign vend_accepted = accepted_q;
	assign scanning      = scanning_q;
	assign vending       = enable_q;

`ifndef SYNTHESIS
	// presence bits are only ever set until the next reset
	a_presence_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((presence_q & $past(presence_q)) == $past(presence_q)))
		else $error("presence map lost a bit");

	// vend phases only occur once the scan has finished
	a_vend_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == mmsv_pkg::PH_START || phase_q == mmsv_pkg::PH_WAIT)
		|-> (mode_q == mmsv_pkg::MODE_IDLE))
		else $error("vend phase outside idle mode");

	// an accepted vend leaves the motor enabled with exactly one row and column
	a_vend_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && accepted_q)
		|-> (enable_q && $onehot(row_drive_q) && $onehot(col_drive_q)))
		else $error("accepted vend without drives");

	// input side waits only while an item sits blocked in the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked item");
`endif

endmodule
